### hdl/tcred_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcred_pkg
// Shared types, codes and helpers of the two-class RED drop decision block.
// ----------------------------------------------------------------------------
package tcred_pkg;

    localparam int SHIFT_TABLE_DEPTH = 256;
    localparam int TBL_AW            = $clog2(SHIFT_TABLE_DEPTH);
    localparam int NUM_CLASSES       = 2;
    localparam int CLS_W             = $clog2(NUM_CLASSES);

    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // request codes
    localparam logic [1:0] REQ_ARRIVAL = 2'd0;
    localparam logic [1:0] REQ_EMPTY   = 2'd1;
    localparam logic [1:0] REQ_TABLE   = 2'd2;

    // decision codes
    localparam logic [1:0] DEC_PASS   = 2'd0;
    localparam logic [1:0] DEC_PROB   = 2'd1;
    localparam logic [1:0] DEC_FORCED = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_TH   = 3'd0;
    localparam logic [2:0] CFG_MAX_TH   = 3'd1;
    localparam logic [2:0] CFG_WLOG     = 3'd2;
    localparam logic [2:0] CFG_CLOG     = 3'd3;
    localparam logic [2:0] CFG_PROB     = 3'd4;
    localparam logic [2:0] CFG_LO_OFF   = 3'd5;

    localparam logic [19:0] RST_MIN_TH = 20'd0;
    localparam logic [19:0] RST_MAX_TH = 20'hFFFFF;
    localparam logic [3:0]  RST_WLOG   = 4'd9;
    localparam logic [4:0]  RST_CLOG   = 5'd10;

    localparam logic [31:0] CLASS0_TOS_LIMIT = 32'd4;
    localparam logic [31:0] BDEC_MIN_QUO     = 32'd15;
    localparam logic [41:0] BDEC_SCALE       = 42'd1000;
    localparam logic [39:0] CELL_LIMIT       = 40'd255;

    typedef enum logic [1:0] {
        RG_BELOW,
        RG_BAND,
        RG_ABOVE
    } t_region;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_EMPTY,
        CMD_TABLE,
        CMD_EWMA,
        CMD_PREP,
        CMD_DIV_STEP,
        CMD_MUL_LO,
        CMD_MUL_HI,
        CMD_LIN,
        CMD_DECAY1,
        CMD_DECAY2,
        CMD_COMMIT,
        CMD_MUL_D,
        CMD_DROP,
        CMD_DRAW
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_LIN,
        ST_DECAY1,
        ST_DECAY2,
        ST_COMMIT,
        ST_CHECK,
        ST_TEST,
        ST_DRAW,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0] req;
        logic       idle_act;
        logic       backlog_zero;
        logic       div_done;
        t_region    region;
        logic       psd_zero;
        logic       drop_hit;
    } t_status;

    typedef struct packed {
        t_cmd cmd;
        logic out_load;
    } t_ctl;

    // threshold scaled by the weight, saturating at all ones
    function automatic logic [31:0] scaled(input logic [19:0] th, input logic [3:0] wl);
        logic [34:0] w;
        w = {15'd0, th} << wl;
        return (|w[34:32]) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

endpackage

### hdl/tcred_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcred_ctrl
// Sequencer: walks one request through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module tcred_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tcred_pkg::t_status i_status,
    output tcred_pkg::t_ctl    o_ctl
);

    tcred_pkg::t_state r_state, n_state;
    logic              r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcred_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ctl.cmd    = tcred_pkg::CMD_NONE;
        o_ctl.out_load = 1'b0;
        o_in_ready   = 1'b0;
        case (r_state)
            tcred_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.cmd = tcred_pkg::CMD_LOAD;
                    n_state   = tcred_pkg::ST_DISPATCH;
                end
            end
            tcred_pkg::ST_DISPATCH: begin
                n_state = tcred_pkg::ST_IDLE;
                case (i_status.req)
                    tcred_pkg::REQ_ARRIVAL: begin
                        if (i_status.idle_act) begin
                            o_ctl.cmd = tcred_pkg::CMD_PREP;
                            n_state   = i_status.backlog_zero ? tcred_pkg::ST_MUL_LO
                                                              : tcred_pkg::ST_DIV;
                        end else begin
                            o_ctl.cmd = tcred_pkg::CMD_EWMA;
                            n_state   = tcred_pkg::ST_COMMIT;
                        end
                    end
                    tcred_pkg::REQ_EMPTY: o_ctl.cmd = tcred_pkg::CMD_EMPTY;
                    tcred_pkg::REQ_TABLE: o_ctl.cmd = tcred_pkg::CMD_TABLE;
                    default: o_ctl.cmd = tcred_pkg::CMD_NONE;
                endcase
            end
            tcred_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = tcred_pkg::ST_MUL_LO;
                end else begin
                    o_ctl.cmd = tcred_pkg::CMD_DIV_STEP;
                end
            end
            tcred_pkg::ST_MUL_LO: begin
                o_ctl.cmd = tcred_pkg::CMD_MUL_LO;
                n_state   = tcred_pkg::ST_MUL_HI;
            end
            tcred_pkg::ST_MUL_HI: begin
                o_ctl.cmd = tcred_pkg::CMD_MUL_HI;
                n_state   = tcred_pkg::ST_LIN;
            end
            tcred_pkg::ST_LIN: begin
                o_ctl.cmd = tcred_pkg::CMD_LIN;
                n_state   = tcred_pkg::ST_DECAY1;
            end
            tcred_pkg::ST_DECAY1: begin
                o_ctl.cmd = tcred_pkg::CMD_DECAY1;
                n_state   = tcred_pkg::ST_DECAY2;
            end
            tcred_pkg::ST_DECAY2: begin
                o_ctl.cmd = tcred_pkg::CMD_DECAY2;
                n_state   = tcred_pkg::ST_COMMIT;
            end
            tcred_pkg::ST_COMMIT: begin
                o_ctl.cmd = tcred_pkg::CMD_COMMIT;
                n_state   = tcred_pkg::ST_CHECK;
            end
            tcred_pkg::ST_CHECK: begin
                if (i_status.region != tcred_pkg::RG_BAND) begin
                    n_state = tcred_pkg::ST_OUT;
                end else if (i_status.psd_zero) begin
                    n_state = tcred_pkg::ST_DRAW;
                end else begin
                    o_ctl.cmd = tcred_pkg::CMD_MUL_D;
                    n_state   = tcred_pkg::ST_TEST;
                end
            end
            tcred_pkg::ST_TEST: begin
                if (i_status.drop_hit) begin
                    o_ctl.cmd = tcred_pkg::CMD_DROP;
                    n_state   = tcred_pkg::ST_DRAW;
                end else begin
                    n_state = tcred_pkg::ST_OUT;
                end
            end
            tcred_pkg::ST_DRAW: begin
                o_ctl.cmd = tcred_pkg::CMD_DRAW;
                n_state   = tcred_pkg::ST_OUT;
            end
            tcred_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = tcred_pkg::ST_IDLE;
                end
            end
            default: n_state = tcred_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |=> r_out_valid)
        else $error("result register not marked valid after load");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_ctl.out_load)
        else $error("pending result overwritten");
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.cmd == tcred_pkg::CMD_LOAD) |=> (r_state == tcred_pkg::ST_DISPATCH))
        else $error("accepted request not dispatched");
`endif

endmodule

### hdl/tcred_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcred_dp
// Datapath: config registers, class state, shift table, divider, multiplier.
// ----------------------------------------------------------------------------
module tcred_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcred_pkg::t_ctl    i_ctl,
    output tcred_pkg::t_status o_status,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_tos_byte,
    input  logic [19:0]        i_backlog_bytes,
    input  logic [31:0]        i_now_us,
    input  logic [31:0]        i_random_word,
    input  logic [7:0]         i_table_index,
    input  logic [4:0]         i_table_value,
    output logic [1:0]         o_decision,
    output logic               o_traffic_class,
    output logic [31:0]        o_new_average
);

    localparam int TD = tcred_pkg::SHIFT_TABLE_DEPTH;
    localparam int AW = tcred_pkg::TBL_AW;
    localparam int NC = tcred_pkg::NUM_CLASSES;

    // configuration
    logic [19:0] r_min_th, r_max_th, r_lo_off;
    logic [3:0]  r_wlog;
    logic [4:0]  r_clog;
    logic [31:0] r_prob;

    // captured request
    logic [1:0]  r_req;
    logic        r_cls;
    logic [19:0] r_backlog;
    logic [31:0] r_now, r_rnd;
    logic [7:0]  r_tidx;
    logic [4:0]  r_tval;

    // block state
    logic [31:0] r_avg_cls [NC];
    logic        r_idle_act [NC];
    logic [31:0] r_idle_start [NC];
    logic [31:0] r_psd;
    logic [31:0] r_rthr;
    logic [4:0]  r_mem [TD];
    logic [TD-1:0] r_tbl_vld;
    logic [4:0]  r_tbl_q;

    // work registers
    logic [31:0] r_idle, r_avg_old, r_quo, r_x, r_avg, r_d;
    logic [19:0] r_rem;
    logic [tcred_pkg::CNT_W-1:0] r_cnt;
    logic [41:0] r_bdec;
    logic [63:0] r_prod, r_lin;
    tcred_pkg::t_region r_region;
    logic [1:0]  r_dec;

    logic [31:0] qmin, qmax, lo_min, idle_raw, idle_clamp, cell_hi, cell_lo;
    logic [39:0] cell_max;
    logic [31:0] tidx_ext;
    logic [20:0] rem_sh;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [32:0] ewma;
    logic [41:0] x1;
    logic [31:0] avg_cur;

    assign qmin     = tcred_pkg::scaled(r_min_th, r_wlog);
    assign qmax     = tcred_pkg::scaled(r_max_th, r_wlog);
    assign lo_min   = (r_cls && (qmin <= {12'd0, r_lo_off})) ? 32'd0 :
                      (r_cls ? qmin - {12'd0, r_lo_off} : qmin);
    assign idle_raw = r_now - r_idle_start[r_cls];
    assign cell_max = tcred_pkg::CELL_LIMIT << r_clog;
    assign idle_clamp = ({8'd0, idle_raw} > cell_max) ? cell_max[31:0] : idle_raw;
    assign cell_hi  = r_idle >> r_clog;
    assign cell_lo  = r_idle & ~(32'hFFFF_FFFF << r_clog);
    assign tidx_ext = {24'd0, r_tidx};
    assign rem_sh   = {r_rem, r_quo[31]};
    assign avg_cur  = r_avg_cls[r_cls];
    assign ewma     = {1'b0, avg_cur} - {1'b0, avg_cur >> r_wlog} + {13'd0, r_backlog};
    assign x1       = ({10'd0, r_x} > r_bdec) ? {10'd0, r_x} - r_bdec : 42'd0;

    // shared multiplier
    always_comb begin
        case (i_ctl.cmd)
            tcred_pkg::CMD_MUL_LO: begin
                mul_a = r_avg_old;
                mul_b = cell_lo;
            end
            tcred_pkg::CMD_MUL_HI: begin
                mul_a = r_avg_old;
                mul_b = cell_hi;
            end
            tcred_pkg::CMD_MUL_D: begin
                mul_a = r_d;
                mul_b = r_psd;
            end
            tcred_pkg::CMD_DRAW: begin
                mul_a = r_rnd;
                mul_b = r_prob;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_th <= tcred_pkg::RST_MIN_TH;
            r_max_th <= tcred_pkg::RST_MAX_TH;
            r_wlog   <= tcred_pkg::RST_WLOG;
            r_clog   <= tcred_pkg::RST_CLOG;
            r_prob   <= 32'd0;
            r_lo_off <= 20'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tcred_pkg::CFG_MIN_TH: r_min_th <= i_cfg_data[19:0];
                tcred_pkg::CFG_MAX_TH: r_max_th <= i_cfg_data[19:0];
                tcred_pkg::CFG_WLOG:   r_wlog   <= i_cfg_data[3:0];
                tcred_pkg::CFG_CLOG:   r_clog   <= i_cfg_data[4:0];
                tcred_pkg::CFG_PROB:   r_prob   <= i_cfg_data;
                tcred_pkg::CFG_LO_OFF: r_lo_off <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // shift table: memory, valid bits, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == tcred_pkg::CMD_TABLE && tidx_ext < TD) begin
            r_mem[tidx_ext[AW-1:0]] <= r_tval;
        end
        r_tbl_q <= r_tbl_vld[cell_hi[AW-1:0]] ? r_mem[cell_hi[AW-1:0]] : 5'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
        end else if (i_ctl.cmd == tcred_pkg::CMD_TABLE && tidx_ext < TD) begin
            r_tbl_vld[tidx_ext[AW-1:0]] <= 1'b1;
        end
    end

    // class state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NC; i++) begin
                r_avg_cls[i]    <= 32'd0;
                r_idle_act[i]   <= 1'b0;
                r_idle_start[i] <= 32'd0;
            end
            r_psd <= 32'hFFFF_FFFF;
            r_cnt <= '0;
        end else begin
            case (i_ctl.cmd)
                tcred_pkg::CMD_EMPTY: begin
                    if (!r_idle_act[r_cls]) begin
                        r_idle_act[r_cls]   <= 1'b1;
                        r_idle_start[r_cls] <= r_now;
                    end
                end
                tcred_pkg::CMD_PREP: r_cnt <= '0;
                tcred_pkg::CMD_DIV_STEP: r_cnt <= r_cnt + 1'b1;
                tcred_pkg::CMD_COMMIT: begin
                    r_avg_cls[r_cls]  <= r_avg;
                    r_idle_act[r_cls] <= 1'b0;
                    if (r_avg < lo_min || r_avg >= qmax) begin
                        r_psd <= 32'hFFFF_FFFF;
                    end else begin
                        r_psd <= r_psd + 32'd1;
                    end
                end
                tcred_pkg::CMD_DROP: r_psd <= 32'd0;
                default: ;
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            tcred_pkg::CMD_LOAD: begin
                r_req     <= i_req_type;
                r_cls     <= ({24'd0, i_tos_byte} < tcred_pkg::CLASS0_TOS_LIMIT) ? 1'b0 : 1'b1;
                r_backlog <= i_backlog_bytes;
                r_now     <= i_now_us;
                r_rnd     <= i_random_word;
                r_tidx    <= i_table_index;
                r_tval    <= i_table_value;
            end
            tcred_pkg::CMD_EWMA: r_avg <= ewma[32] ? 32'hFFFF_FFFF : ewma[31:0];
            tcred_pkg::CMD_PREP: begin
                r_idle    <= idle_clamp;
                r_avg_old <= avg_cur;
                r_quo     <= qmin;
                r_rem     <= 20'd0;
            end
            tcred_pkg::CMD_DIV_STEP: begin
                if (rem_sh >= {1'b0, r_backlog}) begin
                    r_rem <= 20'(rem_sh - {1'b0, r_backlog});
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[19:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
            end
            tcred_pkg::CMD_MUL_LO: begin
                r_bdec <= (r_backlog != 20'd0 && r_quo > tcred_pkg::BDEC_MIN_QUO) ?
                          {10'd0, r_quo} * tcred_pkg::BDEC_SCALE : 42'd0;
                r_prod <= mul_p;
            end
            tcred_pkg::CMD_MUL_HI: begin
                r_lin  <= r_prod >> r_clog;
                r_prod <= mul_p;
            end
            tcred_pkg::CMD_LIN: r_lin <= r_lin + r_prod;
            tcred_pkg::CMD_DECAY1: begin
                if (r_tbl_q != 5'd0) begin
                    r_x <= r_avg_old >> r_tbl_q;
                end else if (r_lin < {32'd0, r_avg_old >> 1}) begin
                    r_x <= r_avg_old - r_lin[31:0];
                end else begin
                    r_x <= r_avg_old >> 1;
                end
            end
            tcred_pkg::CMD_DECAY2: r_avg <= (x1 > r_bdec) ? 32'(x1 - r_bdec) : x1[31:0];
            tcred_pkg::CMD_COMMIT: begin
                r_d <= ((r_avg > qmin) ? r_avg - qmin : 32'd0) >> r_wlog;
                if (r_avg < lo_min) begin
                    r_region <= tcred_pkg::RG_BELOW;
                    r_dec    <= tcred_pkg::DEC_PASS;
                end else if (r_avg >= qmax) begin
                    r_region <= tcred_pkg::RG_ABOVE;
                    r_dec    <= tcred_pkg::DEC_FORCED;
                end else begin
                    r_region <= tcred_pkg::RG_BAND;
                    r_dec    <= tcred_pkg::DEC_PASS;
                end
            end
            tcred_pkg::CMD_MUL_D: r_prod <= mul_p;
            tcred_pkg::CMD_DROP: r_dec <= tcred_pkg::DEC_PROB;
            tcred_pkg::CMD_DRAW: r_rthr <= mul_p[63:32];
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_decision      <= r_dec;
            o_traffic_class <= r_cls;
            o_new_average   <= r_avg;
        end
    end

    assign o_status.req          = r_req;
    assign o_status.idle_act     = r_idle_act[r_cls];
    assign o_status.backlog_zero = (r_backlog == 20'd0);
    assign o_status.div_done     = (r_cnt == tcred_pkg::CNT_W'(tcred_pkg::DIV_STEPS));
    assign o_status.region       = r_region;
    assign o_status.psd_zero     = (r_psd == 32'd0);
    assign o_status.drop_hit     = !(r_prod < {32'd0, r_rthr});

`ifndef ASSERT_OFF
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tcred_pkg::CNT_W'(tcred_pkg::DIV_STEPS))
        else $error("divider ran past its last step");
    a_decay_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.cmd == tcred_pkg::CMD_DECAY2) |=> (r_avg <= r_avg_old))
        else $error("idle decay raised the average");
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.cmd == tcred_pkg::CMD_COMMIT) |=> !r_idle_act[r_cls])
        else $error("class still idling after arrival");
`endif

endmodule

### hdl/two_class_red_drop_decision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_red_drop_decision
// Two-class weighted RED: per-arrival average update and drop decision.
// ----------------------------------------------------------------------------
//  channel  | handshake               | carries
//  ---------+-------------------------+--------------------------------------
//  input    | i_in_valid / o_in_ready | request type, TOS, backlog, time,
//           |                         | random word, table index and value
//  output   | o_out_valid/i_out_ready | decision, traffic class, new average
//  config   | i_cfg_valid/o_cfg_ready | register index, write data
//
//  Flow: one request at a time. A queue-empty or table-write request ends
//  in the dispatch step. An arrival on a busy class takes the EWMA path; one
//  on an idling class runs the 32-step restoring divider (scaled minimum by
//  backlog, skipped at zero backlog) and the shared 32x32 multiplier.
//  Reset: synchronous, active low; no clearing pass, the shift table has a
//  valid bit per entry. Config is always ready.
//  Stalls: a finished result waits in the output register; the next request
//  is accepted meanwhile and holds only at its final step.
// ----------------------------------------------------------------------------
module two_class_red_drop_decision (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_tos_byte,
    input  logic [19:0] i_backlog_bytes,
    input  logic [31:0] i_now_us,
    input  logic [31:0] i_random_word,
    input  logic [7:0]  i_table_index,
    input  logic [4:0]  i_table_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_decision,
    output logic        o_traffic_class,
    output logic [31:0] o_new_average,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    tcred_pkg::t_ctl    ctl;
    tcred_pkg::t_status status;

    // config registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: accepts requests, issues datapath commands, holds the result
    tcred_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_ctl       (ctl)
    );

    // datapath: state, table, divider, multiplier, result payload
    tcred_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_tos_byte      (i_tos_byte),
        .i_backlog_bytes (i_backlog_bytes),
        .i_now_us        (i_now_us),
        .i_random_word   (i_random_word),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .o_decision      (o_decision),
        .o_traffic_class (o_traffic_class),
        .o_new_average   (o_new_average)
    );

endmodule

### tb/two_class_red_drop_decision_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_red_drop_decision_test
// Self-checking bench for the two-class RED drop decision block: a clocked
// driver feeds requests from a queue, a clocked monitor compares every result
// with a cycle-free predictor of averages, idle decay and drop decisions.
// ----------------------------------------------------------------------------
module two_class_red_drop_decision_test;

    // request code the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // extra wait after the queues are empty, with margin for the last request
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [1:0]  req;
        logic [7:0]  tos;
        logic [19:0] backlog;
        logic [31:0] now;
        logic [31:0] rnd;
        logic [7:0]  tidx;
        logic [4:0]  tval;
    } t_red_request;

    typedef struct {
        logic [1:0]  decision;
        logic        cls;
        logic [31:0] avg;
    } t_red_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_tos_byte = '0;
    logic [19:0] i_backlog_bytes = '0;
    logic [31:0] i_now_us = '0;
    logic [31:0] i_random_word = '0;
    logic [7:0]  i_table_index = '0;
    logic [4:0]  i_table_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_decision;
    logic        o_traffic_class;
    logic [31:0] o_new_average;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    two_class_red_drop_decision dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: configuration copy and per-class state
    // ------------------------------------------------------------------
    logic [19:0] cfg_min, cfg_max, cfg_lo_off;
    logic [3:0]  cfg_wlog;
    logic [4:0]  cfg_clog;
    logic [31:0] cfg_prob;

    logic [31:0] avg_by_class [2];
    logic        idling [2];
    logic [31:0] idle_since [2];
    logic [31:0] run_since_drop;
    logic [31:0] drop_threshold;
    logic [4:0]  shift_tbl [256];

    t_red_request pending_reqs [$];
    t_red_verdict expected_verdicts [$];

    int mismatches = 0;
    int n_results = 0, n_prob = 0, n_forced = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    logic [31:0] clock_us = 0;

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
        mismatches++;
    endtask

    function automatic logic [31:0] scale_threshold(logic [19:0] th);
        logic [35:0] w;
        w = {16'd0, th} << cfg_wlog;
        return (|w[35:32]) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [31:0] draw_threshold(logic [31:0] rnd);
        logic [63:0] p;
        p = {32'd0, rnd} * {32'd0, cfg_prob};
        return p[63:32];
    endfunction

    // average after an idle stretch: table shift or linear, then backlog decay
    function automatic logic [31:0] decayed_average(int c, logic [19:0] backlog,
                                                    logic [31:0] now);
        logic [63:0] a, cell_max, idle, bdec, q, x, hi, lo, lin;
        logic [31:0] gap;
        logic [4:0]  sh;
        a = {32'd0, avg_by_class[c]};
        cell_max = 64'd255 << cfg_clog;
        gap = now - idle_since[c];
        idle = {32'd0, gap};
        if (idle > cell_max) idle = cell_max;
        bdec = 0;
        if (backlog != 0) begin
            q = {32'd0, scale_threshold(cfg_min)} / {44'd0, backlog};
            if (q > 15) bdec = q * 1000;
        end
        hi = idle >> cfg_clog;
        sh = shift_tbl[hi[7:0]];
        if (sh != 0) begin
            x = a >> sh;
        end else begin
            lo = idle & ((64'd1 << cfg_clog) - 1);
            lin = a * hi + ((a * lo) >> cfg_clog);
            x = (lin < (a >> 1)) ? a - lin : (a >> 1);
        end
        x = (x > bdec) ? x - bdec : 0;
        if (x > bdec) x -= bdec;
        return x[31:0];
    endfunction

    // apply one accepted request; queue a verdict for arrivals
    function automatic void predict_request(t_red_request r);
        int c;
        logic [63:0] s, d;
        logic [31:0] a, avg, qmin, qmax, lo_min;
        t_red_verdict v;
        c = (r.tos < 8'd4) ? 0 : 1;
        case (r.req)
            tcred_pkg::REQ_EMPTY: begin
                if (!idling[c]) begin
                    idling[c] = 1'b1;
                    idle_since[c] = r.now;
                end
            end
            tcred_pkg::REQ_TABLE: shift_tbl[r.tidx] = r.tval;
            tcred_pkg::REQ_ARRIVAL: begin
                if (idling[c]) begin
                    avg = decayed_average(c, r.backlog, r.now);
                    idling[c] = 1'b0;
                end else begin
                    a = avg_by_class[c];
                    s = {32'd0, a} - {32'd0, a >> cfg_wlog} + {44'd0, r.backlog};
                    avg = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
                end
                avg_by_class[c] = avg;
                qmin = scale_threshold(cfg_min);
                qmax = scale_threshold(cfg_max);
                lo_min = qmin;
                if (c == 1) begin
                    lo_min = (qmin > {12'd0, cfg_lo_off}) ? qmin - {12'd0, cfg_lo_off}
                                                           : 32'd0;
                end
                if (avg < lo_min) begin
                    run_since_drop = '1;
                    v.decision = tcred_pkg::DEC_PASS;
                end else if (avg >= qmax) begin
                    run_since_drop = '1;
                    v.decision = tcred_pkg::DEC_FORCED;
                end else begin
                    v.decision = tcred_pkg::DEC_PASS;
                    run_since_drop++;
                    if (run_since_drop != 0) begin
                        d = {32'd0, (avg > qmin) ? avg - qmin : 32'd0} >> cfg_wlog;
                        if (!(d * run_since_drop < {32'd0, drop_threshold})) begin
                            run_since_drop = 0;
                            drop_threshold = draw_threshold(r.rnd);
                            v.decision = tcred_pkg::DEC_PROB;
                        end
                    end else begin
                        drop_threshold = draw_threshold(r.rnd);
                    end
                end
                v.cls = c[0];
                v.avg = avg;
                expected_verdicts.push_back(v);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: pull the next request, hold it until accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_red_request r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r.req = i_req_type;     r.tos = i_tos_byte;
                r.backlog = i_backlog_bytes; r.now = i_now_us;
                r.rnd = i_random_word;  r.tidx = i_table_index;
                r.tval = i_table_value;
                predict_request(r);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    r = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_req_type <= r.req;         i_tos_byte <= r.tos;
                    i_backlog_bytes <= r.backlog; i_now_us <= r.now;
                    i_random_word <= r.rnd;      i_table_index <= r.tidx;
                    i_table_value <= r.tval;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure and field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_red_verdict v;
        i_out_ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected result, average", 0, o_new_average);
            end else begin
                v = expected_verdicts.pop_front();
                n_results++;
                if (v.decision == tcred_pkg::DEC_PROB) n_prob++;
                if (v.decision == tcred_pkg::DEC_FORCED) n_forced++;
                if (o_decision !== v.decision)
                    report_mismatch("decision", v.decision, o_decision);
                if (o_traffic_class !== v.cls)
                    report_mismatch("traffic class", v.cls, o_traffic_class);
                if (o_new_average !== v.avg)
                    report_mismatch("new average", v.avg, o_new_average);
            end
        end
    end

    // mirror register writes into the predictor as they are accepted
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tcred_pkg::CFG_MIN_TH: cfg_min    = i_cfg_data[19:0];
                tcred_pkg::CFG_MAX_TH: cfg_max    = i_cfg_data[19:0];
                tcred_pkg::CFG_WLOG:   cfg_wlog   = i_cfg_data[3:0];
                tcred_pkg::CFG_CLOG:   cfg_clog   = i_cfg_data[4:0];
                tcred_pkg::CFG_PROB:   cfg_prob   = i_cfg_data;
                tcred_pkg::CFG_LO_OFF: cfg_lo_off = i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // hold until every request is in and every result is out
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_req(logic [1:0] req, logic [7:0] tos, logic [19:0] bl,
                                     logic [31:0] now, logic [31:0] rnd,
                                     logic [7:0] tidx, logic [4:0] tval);
        t_red_request r;
        r.req = req; r.tos = tos; r.backlog = bl; r.now = now;
        r.rnd = rnd; r.tidx = tidx; r.tval = tval;
        pending_reqs.push_back(r);
    endfunction

    // mostly arrivals with backlog near the thresholds, plus idle periods,
    // table writes and ignored requests
    function automatic void queue_random(int n, logic [19:0] min_b, logic [19:0] max_b,
                                         logic [4:0] cl);
        int pick, lo_b, hi_b;
        logic [19:0] bl;
        logic [1:0] req;
        lo_b = min_b - min_b / 4;
        hi_b = max_b + max_b / 4;
        if (hi_b > 20'hFFFFF) hi_b = 20'hFFFFF;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            req = (pick < 8) ? tcred_pkg::REQ_TABLE : (pick < 18) ? tcred_pkg::REQ_EMPTY :
                  (pick < 21) ? REQ_UNUSED : tcred_pkg::REQ_ARRIVAL;
            pick = $urandom_range(0, 99);
            if (pick < 70) bl = 20'($urandom_range(lo_b, hi_b));
            else if (pick < 82) bl = 20'($urandom_range(0, 64));
            else bl = 20'($urandom());
            clock_us += $urandom_range(0, 32'd300 << cl);
            if ($urandom_range(0, 19) == 0) clock_us = $urandom();
            push_req(req, $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom()),
                     bl, clock_us, $urandom(), 8'($urandom()),
                     $urandom_range(0, 2) == 0 ? 5'd0 : 5'($urandom()));
        end
    endfunction

    task automatic run_phase(logic [19:0] mn, logic [19:0] mx, logic [3:0] wl,
                             logic [4:0] cl, logic [31:0] pr, logic [19:0] off,
                             int mode, int n);
        write_reg(tcred_pkg::CFG_MIN_TH, {12'd0, mn});
        write_reg(tcred_pkg::CFG_MAX_TH, {12'd0, mx});
        write_reg(tcred_pkg::CFG_WLOG, {28'd0, wl});
        write_reg(tcred_pkg::CFG_CLOG, {27'd0, cl});
        write_reg(tcred_pkg::CFG_PROB, pr);
        write_reg(tcred_pkg::CFG_LO_OFF, {12'd0, off});
        case (mode)
            1: begin send_idle_pct = 85; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 85; end
            3: begin send_idle_pct = 22; recv_stall_pct = 22; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
        queue_random(n, mn, mx, cl);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_min = tcred_pkg::RST_MIN_TH; cfg_max = tcred_pkg::RST_MAX_TH;
        cfg_wlog = tcred_pkg::RST_WLOG;  cfg_clog = tcred_pkg::RST_CLOG;
        cfg_prob = '0;                   cfg_lo_off = '0;
        for (int c = 0; c < 2; c++) begin
            avg_by_class[c] = '0; idling[c] = 1'b0; idle_since[c] = '0;
        end
        run_since_drop = '1;
        drop_threshold = '0;
        foreach (shift_tbl[j]) shift_tbl[j] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: table extremes, both classes, idle restart, ignored code,
        // field extremes, linear and table decay
        push_req(tcred_pkg::REQ_TABLE, 8'd0, 0, 0, 0, 8'd0, 5'd31);
        push_req(tcred_pkg::REQ_TABLE, 8'd0, 0, 0, 0, 8'd255, 5'd1);
        push_req(tcred_pkg::REQ_TABLE, 8'd0, 0, 0, 0, 8'd3, 5'd2);
        push_req(tcred_pkg::REQ_ARRIVAL, 8'd0, 20'hFFFFF, 32'd0, '1, 8'd0, 5'd0);
        push_req(tcred_pkg::REQ_ARRIVAL, 8'd3, 20'hFFFFF, 32'd10, 32'd0, 8'd0, 5'd0);
        push_req(tcred_pkg::REQ_ARRIVAL, 8'd4, 20'hFFFFF, 32'd20, 32'd5, 8'd0, 5'd0);
        push_req(tcred_pkg::REQ_ARRIVAL, 8'd255, 20'd0, '1, '1, '1, '1);
        push_req(tcred_pkg::REQ_EMPTY, 8'd0, 0, 32'd100, 0, 0, 0);
        push_req(tcred_pkg::REQ_EMPTY, 8'd1, 0, 32'd900000, 0, 0, 0);
        push_req(tcred_pkg::REQ_ARRIVAL, 8'd2, 20'd7, 32'd100 + (32'd3 << 10) + 32'd55,
                 0, 0, 0);
        push_req(tcred_pkg::REQ_EMPTY, 8'd255, 0, 32'hFFFF_FF00, 0, 0, 0);
        push_req(tcred_pkg::REQ_ARRIVAL, 8'd200, 20'd0, 32'd500, 0, 0, 0);
        push_req(tcred_pkg::REQ_EMPTY, 8'd0, 0, 32'd1000, 0, 0, 0);
        push_req(tcred_pkg::REQ_ARRIVAL, 8'd0, 20'd1, 32'd1000 + (32'd7 << 10), 0, 0, 0);
        push_req(tcred_pkg::REQ_EMPTY, 8'd9, 0, 32'd0, 0, 0, 0);
        push_req(tcred_pkg::REQ_ARRIVAL, 8'd9, 20'd3, '1, 0, 0, 0);
        push_req(REQ_UNUSED, '1, '1, '1, '1, '1, '1);
        push_req(tcred_pkg::REQ_ARRIVAL, 8'd4, 20'd1000, 32'd1, 32'h8000_0000, 0, 0);
        wait_drained();

        // random phases over register extremes and every idling pattern
        run_phase(20'd100, 20'd400, 4'd4, 5'd10, 32'h4000_0000, 20'd0, 0, 90);
        run_phase(20'd0, 20'hFFFFF, 4'd0, 5'd0, 32'hFFFF_FFFF, 20'hFFFFF, 1, 85);
        run_phase(20'd2000, 20'd8000, 4'd11, 5'd23, 32'd0, 20'hFFFFF, 2, 85);
        run_phase(20'hFFFFF, 20'hFFFFF, 4'd11, 5'd5, 32'h1234_5678, 20'd1000, 3, 85);
        run_phase(20'd50, 20'd60, 4'd2, 5'd3, 32'h8000_0000, 20'd30, 0, 85);
        run_phase(20'd300, 20'd3000, 4'd6, 5'd15, 32'hFFFF_FFFF, 20'd200, 1, 85);
        run_phase(20'd10, 20'd20000, 4'd1, 5'd1, 32'd1000, 20'd5, 2, 85);
        run_phase(20'd1000, 20'd1200, 4'd3, 5'd8, 32'hC000_0000, 20'hFFFFF, 3, 85);

        $display("Covered %0d arrival results: %0d probabilistic and %0d forced drops,",
                 n_results, n_prob, n_forced);
        $display("over nine register settings and four idling patterns.");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
